FILE: rtl/memory_card_serial_master_defines.svh
// assertion macros for the memory card serial master
// no dependencies, taken in by the top level with `include
`ifndef MEMORY_CARD_SERIAL_MASTER_DEFINES_SVH
`define MEMORY_CARD_SERIAL_MASTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MCSM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define MCSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mcsm_pkg.sv
// types, codes and helpers shared by the memory card serial master
// no dependencies
package mcsm_pkg;

   localparam logic [10:0] MAX_READ_BYTES = 11'd1024;
   localparam logic [7:0]  READ_CMD       = 8'h0e;
   localparam logic [10:0] FRAME_BYTES    = 11'd3;
   localparam logic [10:0] ANSWER_BYTES   = 11'd4;
   localparam logic [7:0]  BYTE_ZEROS     = 8'h00;
   localparam logic [7:0]  BYTE_ONES      = 8'hff;

   // operation modes
   localparam logic [1:0] MODE_CMD  = 2'd0;
   localparam logic [1:0] MODE_READ = 2'd1;
   localparam logic [1:0] MODE_ATR  = 2'd2;
   localparam logic [1:0] MODE_NONE = 2'd3;

   // completion status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_ABSENT = 2'd1;
   localparam logic [1:0] STATUS_NO_ACK = 2'd2;
   localparam logic [1:0] STATUS_BLANK  = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_LOW_TICKS  = 2'd0;
   localparam logic [1:0] CSR_HIGH_TICKS = 2'd1;
   localparam logic [1:0] CSR_ACK_LIMIT  = 2'd2;

   localparam logic [7:0] LOW_TICKS_RESET  = 8'd2;
   localparam logic [7:0] HIGH_TICKS_RESET = 8'd3;
   localparam logic [7:0] ACK_LIMIT_RESET  = 8'd250;

   typedef enum logic [4:0] {
      PH_IDLE, PH_TX_LOW, PH_TX_HIGH, PH_END_LOW, PH_END_RST, PH_END_HIGH,
      PH_END_LOW2, PH_ACK_REL, PH_ACK_HIGH, PH_ACK_LOW, PH_RX_LOW, PH_RX_HIGH,
      PH_TAIL_WAIT, PH_TAIL_RST, PH_AT_A, PH_AT_B, PH_AT_C, PH_AT_D, PH_AT_E,
      PH_AT_TAIL
   } phase_type;

   typedef struct packed {
      logic clk;
      logic rst;
      logic io;
      logic drv;
   } pins_type;

   localparam pins_type PINS_IDLE = '{clk: 1'b0, rst: 1'b0, io: 1'b1, drv: 1'b1};

   typedef struct packed {
      logic [7:0] low_ticks;
      logic [7:0] high_ticks;
      logic [7:0] ack_limit;
   } cfg_type;

   typedef struct packed {
      logic        start_req;
      logic [1:0]  mode;
      logic [7:0]  cmd_code;
      logic [9:0]  address;
      logic [7:0]  data_byte;
      logic [10:0] byte_count;
      logic        io_in;
      logic        card_present;
   } req_type;

   typedef struct packed {
      pins_type   pins;
      logic       busy_res;
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic       rx_last;
      logic       done_res;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      phase_type   phase;
      logic [8:0]  tick_count;
      logic [2:0]  bit_index;
      logic [10:0] byte_index;
      logic [7:0]  shift_reg;
      logic [7:0]  ack_tries;
      logic [9:0]  held_address;
      logic [7:0]  held_cmd;
      logic [7:0]  held_data;
      logic [10:0] held_count;
      logic [1:0]  held_mode;
      logic        answer_nonblank;
      pins_type    pins;
   } state_type;

   // bit of the outgoing 3-byte frame, address bits 9:8 folded into command bits 7:6
   function automatic logic frame_bit(logic [10:0] byte_idx, logic [2:0] bit_idx,
                                      logic [9:0] addr, logic [7:0] cmd,
                                      logic [7:0] data);
      logic [7:0] b;
      if (byte_idx == 11'd0) begin
         b = {addr[9:8], 6'b0} | cmd;
      end else if (byte_idx == 11'd1) begin
         b = addr[7:0];
      end else begin
         b = data;
      end
      return b[bit_idx];
   endfunction

endpackage

FILE: rtl/memory_card_serial_master.sv
// top level of the 3-wire synchronous memory card host master
// depends on mcsm_pkg, mcsm_step and memory_card_serial_master_defines.svh
//
// usage:
//   every req transaction is one 10 us timebase tick carrying the start request,
//   operation mode and frame fields plus the sampled IO line and card detect
//   every req transaction gives exactly one rsp transaction with the card pin
//   levels, the busy flag, a received byte when one completes and the status
//   when an operation finishes; rsp_tlast marks the last byte of a read or answer
//   the result is written into the output register when the tick is accepted, and
//   a tick is taken in every cycle that rsp is not stalled; the whole tick is one
//   pass through the sequencer logic between the state and the output register
//   while rsp is stalled the output register holds and req_tready stays low
//   only until the waiting result is taken, so with rsp_tready high the block
//   sustains one transaction per cycle
//   csr writes set low_ticks (0), high_ticks (1) and ack_limit (2), accepted
//   every cycle, and are meant to happen only while the block is idle
//   reset returns to idle with pins clk 0, rst 0, io driven high, and loads
//   the register defaults 2, 3 and 250
`include "memory_card_serial_master_defines.svh"

module memory_card_serial_master (
   input  logic        clock,
   input  logic        reset,
   // tdata: start_req, cmd_code, address, data_byte, byte_count, io_in, card_present
   input  logic [39:0] req_tdata,
   // tuser: mode
   input  logic [1:0]  req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: clk_out, rst_out, io_out, io_drive, busy_res, rx_byte, rx_valid,
   //        done_res, status, zero fill
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   mcsm_pkg::state_type state_ff;
   mcsm_pkg::state_type state_in;
   mcsm_pkg::rsp_type   rsp_ff;
   mcsm_pkg::rsp_type   rsp_in;
   logic                rsp_valid_ff;
   mcsm_pkg::cfg_type   cfg_ff;
   mcsm_pkg::req_type   req;
   logic                req_accept;

   // unpack the incoming tick
   assign req.start_req    = req_tdata[0];
   assign req.mode         = req_tuser;
   assign req.cmd_code     = req_tdata[8:1];
   assign req.address      = req_tdata[18:9];
   assign req.data_byte    = req_tdata[26:19];
   assign req.byte_count   = req_tdata[37:27];
   assign req.io_in        = req_tdata[38];
   assign req.card_present = req_tdata[39];

   // take a new tick whenever the output register is free or being emptied
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   mcsm_step u_step (
      .st  (state_ff),
      .req (req),
      .cfg (cfg_ff),
      .nx  (state_in),
      .res (rsp_in)
   );

   // sequencer state advances once per accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase           <= mcsm_pkg::PH_IDLE;
         state_ff.tick_count      <= '0;
         state_ff.bit_index       <= '0;
         state_ff.byte_index      <= '0;
         state_ff.shift_reg       <= '0;
         state_ff.ack_tries       <= '0;
         state_ff.held_address    <= '0;
         state_ff.held_cmd        <= '0;
         state_ff.held_data       <= '0;
         state_ff.held_count      <= '0;
         state_ff.held_mode       <= '0;
         state_ff.answer_nonblank <= 1'b0;
         state_ff.pins            <= mcsm_pkg::PINS_IDLE;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // output register, doubles as the skid stage toward the receiver
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   // configuration registers, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_ticks  <= mcsm_pkg::LOW_TICKS_RESET;
         cfg_ff.high_ticks <= mcsm_pkg::HIGH_TICKS_RESET;
         cfg_ff.ack_limit  <= mcsm_pkg::ACK_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mcsm_pkg::CSR_LOW_TICKS:  cfg_ff.low_ticks  <= csr_data;
            mcsm_pkg::CSR_HIGH_TICKS: cfg_ff.high_ticks <= csr_data;
            mcsm_pkg::CSR_ACK_LIMIT:  cfg_ff.ack_limit  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // pack the result
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.rx_last;
   assign rsp_tdata  = {7'b0, rsp_ff.status, rsp_ff.done_res, rsp_ff.rx_valid,
                        rsp_ff.rx_byte, rsp_ff.busy_res, rsp_ff.pins.drv,
                        rsp_ff.pins.io, rsp_ff.pins.rst, rsp_ff.pins.clk};

   // idle always shows the parked pin levels
   `MCSM_ASSERT_NOW(a_idle_pins, clock, reset,
      state_ff.phase == mcsm_pkg::PH_IDLE, state_ff.pins == mcsm_pkg::PINS_IDLE,
      "pins not parked while idle")
   // a finished operation is never reported busy
   `MCSM_ASSERT_NOW(a_done_not_busy, clock, reset,
      rsp_valid_ff && rsp_ff.done_res, !rsp_ff.busy_res,
      "done reported together with busy")
   // last byte marker and status only travel with their qualifiers
   `MCSM_ASSERT_NOW(a_qualified_fields, clock, reset,
      rsp_valid_ff && (rsp_ff.rx_last || (rsp_ff.status != mcsm_pkg::STATUS_OK)),
      (!rsp_ff.rx_last || rsp_ff.rx_valid) &&
      ((rsp_ff.status == mcsm_pkg::STATUS_OK) || rsp_ff.done_res),
      "rx_last or status without its qualifier")
   // a valid start from idle always launches an operation
   `MCSM_ASSERT_NEXT(a_start_launches, clock, reset,
      req_accept && (state_ff.phase == mcsm_pkg::PH_IDLE) && req.start_req &&
      (req.mode != mcsm_pkg::MODE_NONE),
      (state_ff.phase != mcsm_pkg::PH_IDLE) && rsp_ff.busy_res,
      "start request from idle did not launch")

endmodule

FILE: rtl/mcsm_step.sv
// one tick of the card pin sequencer: next state and result from state and input
// depends on mcsm_pkg
module mcsm_step (
   input  mcsm_pkg::state_type st,
   input  mcsm_pkg::req_type   req,
   input  mcsm_pkg::cfg_type   cfg,
   output mcsm_pkg::state_type nx,
   output mcsm_pkg::rsp_type   res
);

   logic [8:0]  t_low;
   logic [8:0]  t_high;
   logic [7:0]  ack_lim;
   logic [8:0]  guard;
   logic [8:0]  tries_inc;
   logic [2:0]  bit_inc;
   logic [10:0] byte_inc;
   logic [7:0]  shift_in;
   logic [10:0] tx_byte;
   logic [7:0]  cmd_sel;
   logic [7:0]  data_sel;
   logic        do_rx;
   logic        do_fin;
   logic [1:0]  fin_status;

   // zero timing or limit acts as one
   assign t_low     = {1'b0, (cfg.low_ticks == 8'd0) ? 8'd1 : cfg.low_ticks};
   assign t_high    = {1'b0, (cfg.high_ticks == 8'd0) ? 8'd1 : cfg.high_ticks};
   assign ack_lim   = (cfg.ack_limit == 8'd0) ? 8'd1 : cfg.ack_limit;
   assign guard     = t_low + t_high;
   assign tries_inc = {1'b0, st.ack_tries} + 9'd1;
   assign bit_inc   = st.bit_index + 3'd1;
   assign byte_inc  = st.byte_index + 11'd1;
   assign shift_in  = {req.io_in, st.shift_reg[7:1]};
   assign tx_byte   = (bit_inc == 3'd0) ? byte_inc : st.byte_index;
   assign cmd_sel   = (req.mode == mcsm_pkg::MODE_READ) ? mcsm_pkg::READ_CMD : req.cmd_code;
   assign data_sel  = (req.mode == mcsm_pkg::MODE_READ) ? {7'b0, req.address[0]}
                                                        : req.data_byte;

   always_comb begin
      nx         = st;
      res        = '0;
      do_rx      = 1'b0;
      do_fin     = 1'b0;
      fin_status = mcsm_pkg::STATUS_OK;

      if (st.phase == mcsm_pkg::PH_IDLE) begin
         if (req.start_req && (req.mode != mcsm_pkg::MODE_NONE)) begin
            nx.held_mode       = req.mode;
            nx.held_address    = req.address;
            nx.held_cmd        = cmd_sel;
            nx.held_data       = data_sel;
            nx.held_count      = (req.byte_count > mcsm_pkg::MAX_READ_BYTES)
                                 ? mcsm_pkg::MAX_READ_BYTES : req.byte_count;
            nx.bit_index       = 3'd0;
            nx.byte_index      = 11'd0;
            nx.shift_reg       = 8'd0;
            nx.ack_tries       = 8'd0;
            nx.answer_nonblank = 1'b0;
            if (req.mode == mcsm_pkg::MODE_ATR) begin
               nx.phase      = mcsm_pkg::PH_AT_A;
               nx.tick_count = guard;
               nx.pins       = '{1'b0, 1'b0, 1'b1, 1'b1};
            end else begin
               nx.phase      = mcsm_pkg::PH_TX_LOW;
               nx.tick_count = t_low;
               nx.pins       = '{1'b0, 1'b1,
                                 mcsm_pkg::frame_bit(11'd0, 3'd0, req.address,
                                                     cmd_sel, data_sel), 1'b1};
            end
         end
      end else if (st.tick_count > 9'd1) begin
         nx.tick_count = st.tick_count - 9'd1;
      end else begin
         case (st.phase)
            mcsm_pkg::PH_TX_LOW: begin
               nx.phase      = mcsm_pkg::PH_TX_HIGH;
               nx.tick_count = t_high;
               nx.pins       = '{1'b1, 1'b1, st.pins.io, 1'b1};
            end
            mcsm_pkg::PH_TX_HIGH: begin
               nx.bit_index  = bit_inc;
               nx.byte_index = tx_byte;
               nx.tick_count = t_low;
               if (tx_byte >= mcsm_pkg::FRAME_BYTES) begin
                  nx.phase = mcsm_pkg::PH_END_LOW;
                  nx.pins  = '{1'b0, 1'b1, st.pins.io, 1'b1};
               end else begin
                  nx.phase = mcsm_pkg::PH_TX_LOW;
                  nx.pins  = '{1'b0, 1'b1,
                               mcsm_pkg::frame_bit(tx_byte, bit_inc, st.held_address,
                                                   st.held_cmd, st.held_data), 1'b1};
               end
            end
            mcsm_pkg::PH_END_LOW: begin
               nx.phase      = mcsm_pkg::PH_END_RST;
               nx.tick_count = t_low;
               nx.pins       = '{1'b0, 1'b0, st.pins.io, 1'b1};
            end
            mcsm_pkg::PH_END_RST: begin
               nx.phase      = mcsm_pkg::PH_END_HIGH;
               nx.tick_count = t_high;
               nx.pins       = '{1'b1, 1'b0, st.pins.io, 1'b1};
            end
            mcsm_pkg::PH_END_HIGH: begin
               nx.phase      = mcsm_pkg::PH_END_LOW2;
               nx.tick_count = t_low;
               nx.pins       = '{1'b0, 1'b0, st.pins.io, 1'b1};
            end
            mcsm_pkg::PH_END_LOW2: begin
               nx.byte_index = 11'd0;
               if (st.held_mode == mcsm_pkg::MODE_CMD) begin
                  nx.phase      = mcsm_pkg::PH_ACK_REL;
                  nx.tick_count = t_high;
                  nx.pins       = '{1'b0, 1'b0, st.pins.io, 1'b0};
               end else if (st.held_count == 11'd0) begin
                  nx.phase      = mcsm_pkg::PH_TAIL_WAIT;
                  nx.tick_count = t_low;
                  nx.pins       = '{1'b0, 1'b0, 1'b1, 1'b1};
               end else begin
                  do_rx = 1'b1;
               end
            end
            mcsm_pkg::PH_ACK_REL: begin
               nx.phase      = mcsm_pkg::PH_ACK_HIGH;
               nx.tick_count = t_high;
               nx.pins       = '{1'b1, 1'b0, st.pins.io, 1'b0};
            end
            mcsm_pkg::PH_ACK_HIGH: begin
               nx.phase      = mcsm_pkg::PH_ACK_LOW;
               nx.tick_count = t_low;
               nx.pins       = '{1'b0, 1'b0, st.pins.io, 1'b0};
            end
            mcsm_pkg::PH_ACK_LOW: begin
               if (!req.io_in) begin
                  do_fin = 1'b1;
               end else begin
                  nx.ack_tries = tries_inc[7:0];
                  if (tries_inc >= {1'b0, ack_lim}) begin
                     do_fin     = 1'b1;
                     fin_status = mcsm_pkg::STATUS_NO_ACK;
                  end else begin
                     nx.phase      = mcsm_pkg::PH_ACK_HIGH;
                     nx.tick_count = t_high;
                     nx.pins       = '{1'b1, 1'b0, st.pins.io, 1'b0};
                  end
               end
            end
            mcsm_pkg::PH_RX_LOW: begin
               nx.phase      = mcsm_pkg::PH_RX_HIGH;
               nx.tick_count = t_high;
               nx.pins       = '{1'b1, 1'b0, st.pins.io, 1'b0};
            end
            mcsm_pkg::PH_RX_HIGH: begin
               nx.shift_reg = shift_in;
               nx.bit_index = bit_inc;
               if (bit_inc != 3'd0) begin
                  nx.phase      = mcsm_pkg::PH_RX_LOW;
                  nx.tick_count = t_low;
                  nx.pins       = '{1'b0, 1'b0, st.pins.io, 1'b0};
               end else begin
                  nx.byte_index = byte_inc;
                  res.rx_valid  = 1'b1;
                  res.rx_byte   = shift_in;
                  if (st.held_mode == mcsm_pkg::MODE_ATR) begin
                     if ((shift_in != mcsm_pkg::BYTE_ZEROS) &&
                         (shift_in != mcsm_pkg::BYTE_ONES)) begin
                        nx.answer_nonblank = 1'b1;
                     end
                     res.rx_last = (byte_inc >= mcsm_pkg::ANSWER_BYTES);
                     if (res.rx_last) begin
                        nx.phase      = mcsm_pkg::PH_AT_TAIL;
                        nx.tick_count = 9'd1;
                        nx.pins       = '{1'b0, 1'b0, 1'b1, 1'b1};
                     end else begin
                        do_rx = 1'b1;
                     end
                  end else begin
                     res.rx_last = (byte_inc >= st.held_count);
                     if (res.rx_last) begin
                        nx.phase      = mcsm_pkg::PH_TAIL_WAIT;
                        nx.tick_count = t_low;
                        nx.pins       = '{1'b0, 1'b0, 1'b1, 1'b1};
                     end else begin
                        do_rx = 1'b1;
                     end
                  end
               end
            end
            mcsm_pkg::PH_TAIL_WAIT: begin
               nx.phase      = mcsm_pkg::PH_TAIL_RST;
               nx.tick_count = t_high;
               nx.pins       = '{1'b0, 1'b1, 1'b1, 1'b1};
            end
            mcsm_pkg::PH_TAIL_RST: begin
               do_fin = 1'b1;
            end
            mcsm_pkg::PH_AT_A: begin
               nx.phase      = mcsm_pkg::PH_AT_B;
               nx.tick_count = guard;
               nx.pins       = '{1'b0, 1'b1, 1'b1, 1'b1};
            end
            mcsm_pkg::PH_AT_B: begin
               nx.phase      = mcsm_pkg::PH_AT_C;
               nx.tick_count = guard;
               nx.pins       = '{1'b1, 1'b1, 1'b1, 1'b1};
            end
            mcsm_pkg::PH_AT_C: begin
               nx.phase      = mcsm_pkg::PH_AT_D;
               nx.tick_count = guard;
               nx.pins       = '{1'b0, 1'b1, 1'b1, 1'b1};
            end
            mcsm_pkg::PH_AT_D: begin
               nx.phase      = mcsm_pkg::PH_AT_E;
               nx.tick_count = guard;
               nx.pins       = '{1'b0, 1'b0, 1'b1, 1'b1};
            end
            mcsm_pkg::PH_AT_E: begin
               nx.byte_index = 11'd0;
               do_rx         = 1'b1;
            end
            mcsm_pkg::PH_AT_TAIL: begin
               do_fin     = 1'b1;
               fin_status = st.answer_nonblank ? mcsm_pkg::STATUS_OK
                                               : mcsm_pkg::STATUS_BLANK;
            end
            default: begin
               do_fin = 1'b1;
            end
         endcase
      end

      // presence check before each byte of a read
      if (do_rx) begin
         if ((st.held_mode == mcsm_pkg::MODE_READ) && !req.card_present) begin
            do_fin     = 1'b1;
            fin_status = mcsm_pkg::STATUS_ABSENT;
         end else begin
            nx.bit_index  = 3'd0;
            nx.shift_reg  = 8'd0;
            nx.phase      = mcsm_pkg::PH_RX_LOW;
            nx.tick_count = t_low;
            nx.pins       = '{1'b0, 1'b0, st.pins.io, 1'b0};
         end
      end

      if (do_fin) begin
         nx.phase      = mcsm_pkg::PH_IDLE;
         nx.tick_count = 9'd0;
         nx.pins       = mcsm_pkg::PINS_IDLE;
         res.done_res  = 1'b1;
         res.status    = fin_status;
      end

      res.pins     = nx.pins;
      res.busy_res = (nx.phase != mcsm_pkg::PH_IDLE);
   end

endmodule
